// ===== rtl/core/msbc_pkg.sv =====
// msbc_pkg: shared types, codes and constants of the snoop bus controller
// used by msbc_ctrl, msbc_datapath and mesi_snoop_bus_controller; no dependencies
`timescale 1ns / 1ps

package msbc_pkg;

    // fixed field widths of the word
    localparam int CACHE_W   = 2;
    localparam int CACHES    = 1 << CACHE_W;
    localparam int ADDR_BITS = 48;
    localparam int TYPE_W    = 3;
    localparam int CMD_W     = 2;
    localparam int KIND_W    = 2;
    localparam int SRC_W     = 3;
    localparam int LAT_W     = 48;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // default request queue depth per cache
    localparam int QUEUE_DEPTH_DEF = 8;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GRANT   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESOLVE = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_QUEUED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_GRANT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_REJECT = 2'd3;

    // request types
    localparam logic [TYPE_W-1:0] T_READ    = 3'd0;
    localparam logic [TYPE_W-1:0] T_UPGRADE = 3'd1;
    localparam logic [TYPE_W-1:0] T_FLUSH   = 3'd3;

    // data sources beyond the cache indexes
    localparam logic [SRC_W-1:0] SRC_MEMORY = 3'd4;
    localparam logic [SRC_W-1:0] SRC_NONE   = 3'd5;

    // configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_BUS_LATENCY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_LATENCY = 2'd1;
    localparam logic [CFG_W-1:0]     BUS_LAT_RESET   = 16'd1;
    localparam logic [CFG_W-1:0]     MEM_LAT_RESET   = 16'd10;

    // controller states
    typedef enum logic [0:0] {
        ST_IDLE,
        ST_GRANT_WAIT
    } msbc_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic enqueue;
        logic reject_input;
        logic grant_issue;
        logic grant_finish;
        logic reject_pending;
        logic resolve;
        logic reject_zero;
    } msbc_ctl_t;

    // status from datapath to controller
    typedef struct packed {
        logic pending_valid;
        logic req_full;
        logic any_queued;
    } msbc_stat_t;

endpackage

// ===== rtl/core/msbc_ctrl.sv =====
// msbc_ctrl: command decode and sequencing state machine
// depends on msbc_pkg for state, command and status types
`timescale 1ns / 1ps

module msbc_ctrl
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [msbc_pkg::CMD_W-1:0] cmd,
    input  msbc_pkg::msbc_stat_t      stat,
    output msbc_pkg::msbc_ctl_t       ctl,
    output logic                      busy
);

    msbc_pkg::msbc_state_t state_reg;
    msbc_pkg::msbc_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= msbc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            msbc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    case (cmd)
                        msbc_pkg::CMD_ENQUEUE:
                        begin
                            if (stat.req_full)
                            begin
                                ctl.reject_input = 1'b1;
                            end
                            else
                            begin
                                ctl.enqueue = 1'b1;
                            end
                        end
                        msbc_pkg::CMD_GRANT:
                        begin
                            if (stat.pending_valid)
                            begin
                                ctl.reject_pending = 1'b1;
                            end
                            else if (stat.any_queued)
                            begin
                                ctl.grant_issue = 1'b1;
                                state_next      = msbc_pkg::ST_GRANT_WAIT;
                            end
                            else
                            begin
                                ctl.reject_zero = 1'b1;
                            end
                        end
                        msbc_pkg::CMD_RESOLVE:
                        begin
                            if (stat.pending_valid)
                            begin
                                ctl.resolve = 1'b1;
                            end
                            else
                            begin
                                ctl.reject_zero = 1'b1;
                            end
                        end
                        default:
                        begin
                            ctl.reject_zero = 1'b1;
                        end
                    endcase
                end
            end
            msbc_pkg::ST_GRANT_WAIT:
            begin
                // store read data is back, finish the grant
                ctl.grant_finish = 1'b1;
                state_next       = msbc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = msbc_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg == msbc_pkg::ST_GRANT_WAIT);

    // at most one datapath operation per cycle
    a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl.enqueue, ctl.reject_input, ctl.grant_issue, ctl.grant_finish,
                  ctl.reject_pending, ctl.resolve, ctl.reject_zero}))
        else $error("more than one datapath operation in a cycle");

    // a grant issue is always followed by its finish
    a_grant_seq: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.grant_issue |=> ctl.grant_finish)
        else $error("grant issue not followed by grant finish");

    // nothing is accepted while a grant waits on the store
    a_busy_hold: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !(ctl.enqueue || ctl.resolve || ctl.grant_issue || ctl.reject_zero))
        else $error("operation started while busy");

endmodule

// ===== rtl/core/msbc_datapath.sv =====
// msbc_datapath: request queues, request store, round-robin pick, snoop resolve,
// latency total, configuration registers and result registers; depends on msbc_pkg
`timescale 1ns / 1ps

module msbc_datapath
#(
    parameter int QUEUE_DEPTH = msbc_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  msbc_pkg::msbc_ctl_t             ctl,
    output msbc_pkg::msbc_stat_t            stat,
    input  logic [msbc_pkg::CACHE_W-1:0]    requester,
    input  logic [msbc_pkg::TYPE_W-1:0]     req_type,
    input  logic [msbc_pkg::ADDR_BITS-1:0]  line_address,
    input  logic [msbc_pkg::CACHES-1:0]     holders_mask,
    input  logic [msbc_pkg::CACHES-1:0]     modified_mask,
    input  logic                            wr_en,
    input  logic [msbc_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [msbc_pkg::CFG_W-1:0]      wr_data,
    output logic                            result_valid,
    output logic [msbc_pkg::KIND_W-1:0]     result_kind,
    output logic [msbc_pkg::CACHE_W-1:0]    owner,
    output logic [msbc_pkg::TYPE_W-1:0]     granted_type,
    output logic [msbc_pkg::ADDR_BITS-1:0]  granted_address,
    output logic [msbc_pkg::SRC_W-1:0]      data_source,
    output logic                            data_shared,
    output logic                            memory_write,
    output logic                            invalidate_others,
    output logic [msbc_pkg::LAT_W-1:0]      elapsed_cycles
);

    localparam int CACHES    = msbc_pkg::CACHES;
    localparam int CACHE_W   = msbc_pkg::CACHE_W;
    localparam int TYPE_W    = msbc_pkg::TYPE_W;
    localparam int ADDR_W    = msbc_pkg::ADDR_BITS;
    localparam int LAT_W     = msbc_pkg::LAT_W;
    localparam int CFG_W     = msbc_pkg::CFG_W;
    localparam int PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W     = PTR_W + 1;
    localparam int MEM_AW    = CACHE_W + PTR_W;
    localparam int MEM_DEPTH = 1 << MEM_AW;
    localparam int ENTRY_W   = TYPE_W + ADDR_W;
    localparam int CHG_W     = CFG_W + 1;

    // request store
    logic [ENTRY_W-1:0] store_mem [MEM_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [MEM_AW-1:0]  wr_addr;
    logic [MEM_AW-1:0]  rd_addr;

    // per cache queue pointers
    logic [FILL_W-1:0]  fill_reg [CACHES];
    logic [FILL_W-1:0]  fill_next [CACHES];
    logic [PTR_W-1:0]   head_reg [CACHES];
    logic [PTR_W-1:0]   head_next [CACHES];
    logic [CACHES-1:0]  nonempty;
    logic [CACHE_W-1:0] rr_reg;

    // pending transaction
    logic                pending_valid_reg;
    logic [CACHE_W-1:0]  pending_owner_reg;
    logic [TYPE_W-1:0]   pending_type_reg;
    logic [ADDR_W-1:0]   pending_addr_reg;

    // configuration and latency
    logic [CFG_W-1:0]    bus_lat_reg;
    logic [CFG_W-1:0]    mem_lat_reg;
    logic [LAT_W-1:0]    latency_reg;
    logic [LAT_W-1:0]    latency_next;

    // result registers
    logic                result_valid_reg;
    logic [msbc_pkg::KIND_W-1:0] kind_reg, kind_next;
    logic [CACHE_W-1:0]  owner_reg, owner_next;
    logic [TYPE_W-1:0]   type_reg, type_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [msbc_pkg::SRC_W-1:0] src_reg, src_next;
    logic                shared_reg, shared_next;
    logic                mwrite_reg, mwrite_next;
    logic                inval_reg, inval_next;

    // requester queue view
    logic [FILL_W-1:0]   req_fill;
    logic [PTR_W-1:0]    req_head;
    logic [SUM_W-1:0]    tail_sum;
    logic [PTR_W-1:0]    tail;

    // round-robin pick
    logic                found;
    logic [CACHE_W-1:0]  pick;
    logic [PTR_W-1:0]    pick_head;
    logic [SUM_W-1:0]    head_sum;
    logic [PTR_W-1:0]    head_inc;

    // snoop resolve
    logic [CACHES-1:0]   others;
    logic [CACHES-1:0]   hold_o;
    logic [CACHES-1:0]   mod_o;
    logic [CACHE_W-1:0]  first_mod;
    logic                is_read;
    logic                is_upgrade;
    logic                is_flush;
    logic [CHG_W-1:0]    extra_charge;
    logic [CHG_W-1:0]    step_charge;
    logic [LAT_W:0]      lat_sum;

    // requester queue state and write slot
    always_comb
    begin
        req_fill = '0;
        req_head = '0;
        for (int c = 0; c < CACHES; c++)
        begin
            if (requester == CACHE_W'(c))
            begin
                req_fill = fill_reg[c];
                req_head = head_reg[c];
            end
        end
        tail_sum = {1'b0, req_head} + SUM_W'(req_fill);
        if (tail_sum >= SUM_W'(QUEUE_DEPTH))
        begin
            tail_sum = tail_sum - SUM_W'(QUEUE_DEPTH);
        end
        tail = tail_sum[PTR_W-1:0];
    end

    assign wr_addr = {requester, tail};

    // round-robin search from rr_reg over non-empty queues
    always_comb
    begin
        for (int c = 0; c < CACHES; c++)
        begin
            nonempty[c] = (fill_reg[c] != '0);
        end
    end

    always_comb
    begin
        logic [CACHE_W-1:0] idx;
        found = 1'b0;
        pick  = '0;
        idx   = '0;
        for (int k = 0; k < CACHES; k++)
        begin
            idx = rr_reg + CACHE_W'(k);
            if (!found && nonempty[idx])
            begin
                found = 1'b1;
                pick  = idx;
            end
        end
    end

    always_comb
    begin
        pick_head = '0;
        for (int c = 0; c < CACHES; c++)
        begin
            if (pick == CACHE_W'(c))
            begin
                pick_head = head_reg[c];
            end
        end
        head_sum = {1'b0, pick_head} + SUM_W'(1);
        if (head_sum == SUM_W'(QUEUE_DEPTH))
        begin
            head_sum = '0;
        end
        head_inc = head_sum[PTR_W-1:0];
    end

    assign rd_addr = {pick, pick_head};

    // status toward the controller
    assign stat.pending_valid = pending_valid_reg;
    assign stat.req_full      = (req_fill == FILL_W'(QUEUE_DEPTH));
    assign stat.any_queued    = found;

    // queue pointer updates
    always_comb
    begin
        for (int c = 0; c < CACHES; c++)
        begin
            fill_next[c] = fill_reg[c];
            head_next[c] = head_reg[c];
            if (ctl.enqueue && requester == CACHE_W'(c))
            begin
                fill_next[c] = fill_reg[c] + FILL_W'(1);
            end
            if (ctl.grant_issue && pick == CACHE_W'(c))
            begin
                fill_next[c] = fill_reg[c] - FILL_W'(1);
                head_next[c] = head_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CACHES; c++)
            begin
                fill_reg[c] <= '0;
                head_reg[c] <= '0;
            end
            rr_reg <= '0;
        end
        else
        begin
            for (int c = 0; c < CACHES; c++)
            begin
                fill_reg[c] <= fill_next[c];
                head_reg[c] <= head_next[c];
            end
            if (ctl.grant_issue)
            begin
                rr_reg <= pick + CACHE_W'(1);
            end
        end
    end

    // store write on enqueue
    always_ff @(posedge clk)
    begin
        if (ctl.enqueue)
        begin
            store_mem[wr_addr] <= {req_type, line_address};
        end
    end

    // registered store read on grant
    always_ff @(posedge clk)
    begin
        if (ctl.grant_issue)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    // pending transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_valid_reg <= 1'b0;
            pending_owner_reg <= '0;
            pending_type_reg  <= '0;
            pending_addr_reg  <= '0;
        end
        else
        begin
            if (ctl.grant_issue)
            begin
                pending_valid_reg <= 1'b1;
                pending_owner_reg <= pick;
            end
            else if (ctl.resolve)
            begin
                pending_valid_reg <= 1'b0;
            end
            if (ctl.grant_finish)
            begin
                pending_type_reg <= rd_data_reg[ENTRY_W-1:ADDR_W];
                pending_addr_reg <= rd_data_reg[ADDR_W-1:0];
            end
        end
    end

    // snoop resolve: other holders, lowest modified cache
    always_comb
    begin
        others = ~(CACHES'(1) << pending_owner_reg);
        hold_o = holders_mask & others;
        mod_o  = modified_mask & others;
        first_mod = '0;
        for (int i = CACHES - 1; i >= 0; i--)
        begin
            if (mod_o[i])
            begin
                first_mod = CACHE_W'(i);
            end
        end
    end

    assign is_read    = (pending_type_reg == msbc_pkg::T_READ);
    assign is_upgrade = (pending_type_reg == msbc_pkg::T_UPGRADE);
    assign is_flush   = (pending_type_reg == msbc_pkg::T_FLUSH);

    // latency charge with saturation
    always_comb
    begin
        extra_charge = '0;
        if (is_read || is_upgrade)
        begin
            extra_charge = (mod_o != '0) ? CHG_W'(bus_lat_reg) : CHG_W'(mem_lat_reg);
        end
        else if (is_flush)
        begin
            extra_charge = CHG_W'(mem_lat_reg);
        end
        step_charge  = CHG_W'(bus_lat_reg) + extra_charge;
        lat_sum      = {1'b0, latency_reg} + (LAT_W + 1)'(step_charge);
        latency_next = lat_sum[LAT_W] ? '1 : lat_sum[LAT_W-1:0];
    end

    // configuration registers and latency total
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_lat_reg <= msbc_pkg::BUS_LAT_RESET;
            mem_lat_reg <= msbc_pkg::MEM_LAT_RESET;
            latency_reg <= '0;
        end
        else
        begin
            if (wr_en && wr_index == msbc_pkg::CFG_BUS_LATENCY)
            begin
                bus_lat_reg <= wr_data;
            end
            if (wr_en && wr_index == msbc_pkg::CFG_MEM_LATENCY)
            begin
                mem_lat_reg <= wr_data;
            end
            if (ctl.resolve)
            begin
                latency_reg <= latency_next;
            end
        end
    end

    // result word selection
    always_comb
    begin
        kind_next   = msbc_pkg::KIND_REJECT;
        owner_next  = '0;
        type_next   = '0;
        addr_next   = '0;
        src_next    = msbc_pkg::SRC_NONE;
        shared_next = 1'b0;
        mwrite_next = 1'b0;
        inval_next  = 1'b0;
        if (ctl.enqueue || ctl.reject_input)
        begin
            kind_next  = ctl.enqueue ? msbc_pkg::KIND_QUEUED : msbc_pkg::KIND_REJECT;
            owner_next = requester;
            type_next  = req_type;
            addr_next  = line_address;
        end
        else if (ctl.grant_finish)
        begin
            kind_next  = msbc_pkg::KIND_GRANT;
            owner_next = pending_owner_reg;
            type_next  = rd_data_reg[ENTRY_W-1:ADDR_W];
            addr_next  = rd_data_reg[ADDR_W-1:0];
        end
        else if (ctl.reject_pending)
        begin
            owner_next = pending_owner_reg;
            type_next  = pending_type_reg;
            addr_next  = pending_addr_reg;
        end
        else if (ctl.resolve)
        begin
            kind_next  = msbc_pkg::KIND_DONE;
            owner_next = pending_owner_reg;
            type_next  = pending_type_reg;
            addr_next  = pending_addr_reg;
            if (is_read || is_upgrade)
            begin
                inval_next = is_upgrade;
                if (mod_o != '0)
                begin
                    src_next    = msbc_pkg::SRC_W'(first_mod);
                    shared_next = is_read;
                end
                else
                begin
                    src_next    = msbc_pkg::SRC_MEMORY;
                    shared_next = is_read && (hold_o != '0);
                end
            end
            else if (is_flush)
            begin
                mwrite_next = 1'b1;
            end
        end
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= ctl.enqueue || ctl.reject_input || ctl.grant_finish
                                || ctl.reject_pending || ctl.resolve || ctl.reject_zero;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        owner_reg  <= owner_next;
        type_reg   <= type_next;
        addr_reg   <= addr_next;
        src_reg    <= src_next;
        shared_reg <= shared_next;
        mwrite_reg <= mwrite_next;
        inval_reg  <= inval_next;
    end

    assign result_valid      = result_valid_reg;
    assign result_kind       = kind_reg;
    assign owner             = owner_reg;
    assign granted_type      = type_reg;
    assign granted_address   = addr_reg;
    assign data_source       = src_reg;
    assign data_shared       = shared_reg;
    assign memory_write      = mwrite_reg;
    assign invalidate_others = inval_reg;
    assign elapsed_cycles    = latency_reg;

    // grant finish only on a transaction set up by the issue
    a_finish_pending: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.grant_finish |-> pending_valid_reg)
        else $error("grant finish without pending transaction");

    // the latency total never goes down
    a_lat_mono: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.resolve |=> latency_reg >= $past(latency_reg))
        else $error("latency total decreased");

    // no queue is popped while empty or pushed while full
    a_queue_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.grant_issue && !nonempty[pick]) && !(ctl.enqueue && stat.req_full))
        else $error("queue pointer out of range");

endmodule

// ===== rtl/core/mesi_snoop_bus_controller.sv =====
// channel   | signals                                         | handshake
// command   | cmd requester req_type line_address masks       | start & !busy
// result    | result_kind owner granted_* data_* ... elapsed   | result_valid, one cycle
// config    | wr_index wr_data                                | wr_en
//
// enqueue, resolve and every rejected word are done from ST_IDLE alone; a grant also passes
// through ST_GRANT_WAIT for the registered read port of the request store (busy high there).
// results are registered and shown for one cycle; the receiver cannot stall.
// reset empties all queues and clears pending state; no store clearing pass.
// top level of the snoop bus controller; depends on msbc_pkg, msbc_ctrl, msbc_datapath
`timescale 1ns / 1ps

module mesi_snoop_bus_controller
#(
    parameter int QUEUE_DEPTH = msbc_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [msbc_pkg::CMD_W-1:0]      cmd,
    input  logic [msbc_pkg::CACHE_W-1:0]    requester,
    input  logic [msbc_pkg::TYPE_W-1:0]     req_type,
    input  logic [msbc_pkg::ADDR_BITS-1:0]  line_address,
    input  logic [msbc_pkg::CACHES-1:0]     holders_mask,
    input  logic [msbc_pkg::CACHES-1:0]     modified_mask,
    input  logic                            wr_en,
    input  logic [msbc_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [msbc_pkg::CFG_W-1:0]      wr_data,
    output logic                            result_valid,
    output logic [msbc_pkg::KIND_W-1:0]     result_kind,
    output logic [msbc_pkg::CACHE_W-1:0]    owner,
    output logic [msbc_pkg::TYPE_W-1:0]     granted_type,
    output logic [msbc_pkg::ADDR_BITS-1:0]  granted_address,
    output logic [msbc_pkg::SRC_W-1:0]      data_source,
    output logic                            data_shared,
    output logic                            memory_write,
    output logic                            invalidate_others,
    output logic [msbc_pkg::LAT_W-1:0]      elapsed_cycles
);

    msbc_pkg::msbc_ctl_t  ctl;
    msbc_pkg::msbc_stat_t stat;

    // sequencing
    msbc_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy)
    );

    // queues, resolve and result registers
    msbc_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .ctl               (ctl),
        .stat              (stat),
        .requester         (requester),
        .req_type          (req_type),
        .line_address      (line_address),
        .holders_mask      (holders_mask),
        .modified_mask     (modified_mask),
        .wr_en             (wr_en),
        .wr_index          (wr_index),
        .wr_data           (wr_data),
        .result_valid      (result_valid),
        .result_kind       (result_kind),
        .owner             (owner),
        .granted_type      (granted_type),
        .granted_address   (granted_address),
        .data_source       (data_source),
        .data_shared       (data_shared),
        .memory_write      (memory_write),
        .invalidate_others (invalidate_others),
        .elapsed_cycles    (elapsed_cycles)
    );

endmodule
